// File: design/dq_pkg.sv
package dq_pkg;

    // Data and field widths
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    // Default number of queue entries
    localparam int DEPTH_DEFAULT = 16;

    // Request codes
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_FRONT = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_BACK  = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // Value answered by a pop or read on an empty queue
    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

endpackage

// File: design/double_ended_queue.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------
// request  | in_valid / in_stall   | op [2:0], value_in [31:0]
// result   | out_valid / out_stall | value_out [31:0], status [1:0]
//
// Pushes, empty pops/reads and unused codes: the result is registered at the
// transfer edge and shows on the following cycle. Pops and reads of a held
// entry go through the memory: the entry is read into a data register at
// the transfer edge; the read state then copies it into the output register.
// No new request is taken while the read state is in progress.
// Reset empties the queue at once; the entry memory is not cleared.
// A stalled result holds the output register; a new request is taken
// only when that register is free or being emptied in the same cycle.
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dq_pkg::OP_W-1:0]             op,
    input  logic signed [dq_pkg::DATA_W-1:0]    value_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [dq_pkg::DATA_W-1:0]    value_out,
    output logic [dq_pkg::STATUS_W-1:0]         status
);
    import dq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t                  state_reg;
    logic [PTR_W-1:0]        head_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    out_valid_reg;
    logic signed [DATA_W-1:0] value_out_reg;
    logic [STATUS_W-1:0]     status_reg;

    logic [DATA_W-1:0]       mem [DEPTH];
    logic [DATA_W-1:0]       rd_data_reg;

    logic                    in_xfer;
    logic                    out_free;
    logic                    is_empty;
    logic                    is_full;
    logic [SUM_W-1:0]        tail_sum;
    logic [SUM_W-1:0]        back_sum;
    logic [PTR_W-1:0]        tail_slot;
    logic [PTR_W-1:0]        back_slot;
    logic [PTR_W-1:0]        head_inc;
    logic [PTR_W-1:0]        head_dec;

    logic                    mem_we;
    logic [PTR_W-1:0]        mem_waddr;
    logic                    mem_re;
    logic [PTR_W-1:0]        mem_raddr;

    // Handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) && out_free);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign value_out = value_out_reg;
    assign status    = status_reg;

    // Ring pointer arithmetic, sums stay below twice the depth
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign back_sum  = tail_sum - SUM_W'(1);
    assign tail_slot = (tail_sum >= DEPTH_S) ? PTR_W'(tail_sum - DEPTH_S) : PTR_W'(tail_sum);
    assign back_slot = (back_sum >= DEPTH_S) ? PTR_W'(back_sum - DEPTH_S) : PTR_W'(back_sum);
    assign head_inc  = (head_reg == LAST_SLOT) ? '0 : head_reg + PTR_W'(1);
    assign head_dec  = (head_reg == '0) ? LAST_SLOT : head_reg - PTR_W'(1);

    // Memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = tail_slot;
        mem_re    = 1'b0;
        mem_raddr = head_reg;
        if (in_xfer)
        begin
            unique case (op) inside
                OP_PUSH_BACK:
                begin
                    mem_we    = !is_full;
                    mem_waddr = tail_slot;
                end
                OP_PUSH_FRONT:
                begin
                    mem_we    = !is_full;
                    mem_waddr = head_dec;
                end
                OP_POP_FRONT, OP_READ_FRONT:
                begin
                    mem_re    = !is_empty;
                    mem_raddr = head_reg;
                end
                OP_POP_BACK, OP_READ_BACK:
                begin
                    mem_re    = !is_empty;
                    mem_raddr = back_slot;
                end
                default:
                begin
                    mem_we = 1'b0;
                    mem_re = 1'b0;
                end
            endcase
        end
    end

    // Entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= value_in;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Sequencer, pointers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            value_out_reg <= '0;
            status_reg    <= STAT_OK;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        unique case (op) inside
                            OP_PUSH_BACK, OP_PUSH_FRONT:
                            begin
                                out_valid_reg <= 1'b1;
                                value_out_reg <= '0;
                                if (is_full)
                                begin
                                    status_reg <= STAT_FULL;
                                end
                                else
                                begin
                                    status_reg <= STAT_OK;
                                    count_reg  <= count_reg + CNT_W'(1);
                                    if (op == OP_PUSH_FRONT)
                                    begin
                                        head_reg <= head_dec;
                                    end
                                end
                            end
                            OP_POP_FRONT, OP_POP_BACK, OP_READ_FRONT, OP_READ_BACK:
                            begin
                                if (is_empty)
                                begin
                                    out_valid_reg <= 1'b1;
                                    value_out_reg <= EMPTY_VALUE;
                                    status_reg    <= STAT_EMPTY;
                                end
                                else
                                begin
                                    // result follows from the memory read
                                    out_valid_reg <= 1'b0;
                                    state_reg     <= ST_READ;
                                    if (op == OP_POP_FRONT)
                                    begin
                                        head_reg  <= head_inc;
                                        count_reg <= count_reg - CNT_W'(1);
                                    end
                                    else if (op == OP_POP_BACK)
                                    begin
                                        count_reg <= count_reg - CNT_W'(1);
                                    end
                                end
                            end
                            default:
                            begin
                                // unused codes: no change, zero result
                                out_valid_reg <= 1'b1;
                                value_out_reg <= '0;
                                status_reg    <= STAT_OK;
                            end
                        endcase
                    end
                    else if (!out_stall)
                    begin
                        // result leaves with nothing new behind it
                        out_valid_reg <= 1'b0;
                    end
                end
                ST_READ:
                begin
                    // output register is free: it was freed at the transfer
                    out_valid_reg <= 1'b1;
                    value_out_reg <= rd_data_reg;
                    status_reg    <= STAT_OK;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Fill count never passes the depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // A push on a full queue leaves the pointers alone
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && is_full && (op == OP_PUSH_BACK || op == OP_PUSH_FRONT))
        |=> ($stable(count_reg) && $stable(head_reg)))
        else $error("dropped push changed the queue");

    // A memory read always delivers its result on the next cycle
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("read result not delivered");

    // A nonempty pop or read goes through the memory read
    a_read_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !is_empty && (op == OP_POP_FRONT || op == OP_POP_BACK ||
         op == OP_READ_FRONT || op == OP_READ_BACK)) |=> (state_reg == ST_READ))
        else $error("memory read not issued");

endmodule
